@@ rtl/i2cw_pkg.sv @@
`default_nettype none

package i2cw_pkg;

    // request kinds
    localparam logic [1:0] KIND_COMMAND  = 2'd0;
    localparam logic [1:0] KIND_DATA     = 2'd1;
    localparam logic [1:0] KIND_PROBE    = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    // control bytes that follow the address byte
    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;

    // configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD    = 1'd1;

    localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd60;
    localparam logic [15:0] HALF_PERIOD_RESET    = 16'd4;

    localparam int CMD_QUEUE_DEPTH_DEFAULT = 2;
    localparam int RES_QUEUE_DEPTH_DEFAULT = 2;

    // one tick after classification
    typedef struct packed {
        logic       start;
        logic [1:0] kind;
        logic [7:0] payload;
        logic       sda_in;
    } t_item;

    // bus levels and status for one tick
    typedef struct packed {
        logic scl;
        logic sda_out;
        logic sda_drive;
        logic busy_res;
        logic done_res;
        logic nack_seen;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/i2cw_fifo.sv @@
`default_nettype none

module i2cw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/i2cw_front.sv @@
`default_nettype none

module i2cw_front
    import i2cw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       i_request,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_payload,
    input  wire logic       i_sda_in,
    output logic            o_q_push,
    output t_item           o_q_item,
    input  wire logic       i_q_full
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  take;

    // holding register frees up whenever the queue takes its content
    assign full     = r_valid && i_q_full;
    assign take     = push && !full;
    assign o_q_push = r_valid;
    assign o_q_item = r_item;

    always_comb begin
        n_item.start   = i_request && (i_kind != KIND_RESERVED);
        n_item.kind    = i_kind;
        n_item.payload = i_payload;
        n_item.sda_in  = i_sda_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/i2cw_back.sv @@
`default_nettype none

module i2cw_back
    import i2cw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_item_valid,
    input  t_item                      i_item,
    output logic                       o_item_pop,
    output logic                       o_res_push,
    output t_result                    o_res,
    input  wire logic                  i_res_full
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_HI,
        PH_START_LO,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_STOP_LOW,
        PH_STOP_CLK,
        PH_STOP_REL
    } t_phase;

    t_phase      r_phase, n_phase, e_phase;
    logic [15:0] r_tick, n_tick, e_tick;
    logic [3:0]  r_bit, n_bit, e_bit, bit_inc;
    logic [1:0]  r_byte, n_byte, e_byte, byte_inc;
    logic [7:0]  r_shift, n_shift;
    logic [1:0]  r_kind, e_kind;
    logic [7:0]  r_payload, e_payload;
    logic        r_nack, n_nack, e_nack;
    logic [6:0]  r_dev_addr;
    logic [15:0] r_half, half;
    logic        start, last, more_bytes, fire;
    t_result     res;

    function automatic logic [7:0] frame_byte(
        input logic [1:0] kind,
        input logic [7:0] payload,
        input logic [6:0] dev_addr,
        input logic [1:0] idx
    );
        logic [7:0] b;
        if (kind == KIND_PROBE) begin
            b = {payload[6:0], 1'b0};
        end else if (idx == 2'd0) begin
            b = {dev_addr, 1'b0};
        end else if (idx == 2'd1) begin
            b = (kind == KIND_DATA) ? CTRL_DATA : CTRL_COMMAND;
        end else begin
            b = payload;
        end
        return b;
    endfunction

    assign fire       = i_item_valid && !i_res_full;
    assign o_item_pop = fire;
    assign o_res_push = fire;
    assign o_res      = res;

    always_comb begin
        start     = i_item.start && (r_phase == PH_IDLE);
        e_phase   = start ? PH_START_HI : r_phase;
        e_tick    = start ? 16'd0 : r_tick;
        e_bit     = start ? 4'd0 : r_bit;
        e_byte    = start ? 2'd0 : r_byte;
        e_kind    = start ? i_item.kind : r_kind;
        e_payload = start ? i_item.payload : r_payload;
        e_nack    = start ? 1'b0 : r_nack;

        n_phase = e_phase;
        n_tick  = e_tick;
        n_bit   = e_bit;
        n_byte  = e_byte;
        n_shift = r_shift;
        n_nack  = e_nack;

        half       = (r_half == 16'd0) ? 16'd1 : r_half;
        last       = ({1'b0, e_tick} + 17'd1) >= {1'b0, half};
        bit_inc    = e_bit + 4'd1;
        byte_inc   = e_byte + 2'd1;
        more_bytes = (e_kind == KIND_PROBE) ? 1'b0 : (byte_inc != 2'd3);

        res.scl       = 1'b1;
        res.sda_out   = 1'b1;
        res.sda_drive = 1'b1;
        res.busy_res  = 1'b1;
        res.done_res  = 1'b0;
        res.nack_seen = 1'b0;

        case (e_phase)
            PH_START_HI: begin
            end
            PH_START_LO: begin
                res.sda_out = 1'b0;
            end
            PH_BIT_LOW: begin
                res.scl     = 1'b0;
                res.sda_out = r_shift[7];
            end
            PH_BIT_HIGH: begin
                res.sda_out = r_shift[7];
            end
            PH_ACK_LOW: begin
                res.scl       = 1'b0;
                res.sda_drive = 1'b0;
            end
            PH_ACK_HIGH: begin
                res.sda_drive = 1'b0;
                // acknowledge sampled on the first tick of the high half
                if (e_tick == 16'd0 && i_item.sda_in) begin
                    n_nack = 1'b1;
                end
            end
            PH_STOP_LOW: begin
                res.scl     = 1'b0;
                res.sda_out = 1'b0;
            end
            PH_STOP_CLK: begin
                res.sda_out = 1'b0;
            end
            PH_STOP_REL: begin
            end
            default: begin
                res.busy_res = 1'b0;
            end
        endcase

        if (e_phase != PH_IDLE) begin
            if (!last) begin
                n_tick = e_tick + 16'd1;
            end else begin
                n_tick = 16'd0;
                case (e_phase)
                    PH_START_HI: begin
                        n_phase = PH_START_LO;
                    end
                    PH_START_LO: begin
                        n_shift = frame_byte(e_kind, e_payload, r_dev_addr, 2'd0);
                        n_bit   = 4'd0;
                        n_phase = PH_BIT_LOW;
                    end
                    PH_BIT_LOW: begin
                        n_phase = PH_BIT_HIGH;
                    end
                    PH_BIT_HIGH: begin
                        n_shift = {r_shift[6:0], 1'b0};
                        n_bit   = bit_inc;
                        n_phase = bit_inc[3] ? PH_ACK_LOW : PH_BIT_LOW;
                    end
                    PH_ACK_LOW: begin
                        n_phase = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH: begin
                        n_byte = byte_inc;
                        if (more_bytes) begin
                            n_shift = frame_byte(e_kind, e_payload, r_dev_addr, byte_inc);
                            n_bit   = 4'd0;
                            n_phase = PH_BIT_LOW;
                        end else begin
                            n_phase = PH_STOP_LOW;
                        end
                    end
                    PH_STOP_LOW: begin
                        n_phase = PH_STOP_CLK;
                    end
                    PH_STOP_CLK: begin
                        n_phase = PH_STOP_REL;
                    end
                    default: begin
                        res.done_res  = 1'b1;
                        res.nack_seen = n_nack;
                        n_phase       = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_tick     <= '0;
            r_bit      <= '0;
            r_byte     <= '0;
            r_shift    <= '0;
            r_kind     <= '0;
            r_payload  <= '0;
            r_nack     <= 1'b0;
            r_dev_addr <= DEVICE_ADDRESS_RESET;
            r_half     <= HALF_PERIOD_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEVICE_ADDRESS: r_dev_addr <= i_cfg_data[6:0];
                    REG_HALF_PERIOD:    r_half     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (fire) begin
                r_phase   <= n_phase;
                r_tick    <= n_tick;
                r_bit     <= n_bit;
                r_byte    <= n_byte;
                r_shift   <= n_shift;
                r_kind    <= e_kind;
                r_payload <= e_payload;
                r_nack    <= n_nack;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/i2c_master_write_engine.sv @@
// Write-only I2C master stepped by tick items: every transfer on the input
// queue is one timing tick and yields exactly one result transfer with the
// SCL/SDA levels, busy, and a one-tick done pulse with the NACK summary.
// Sustained rate is one tick per clock when nothing stalls. Ticks pass an
// input holding register, a small command queue, the bit engine (one step
// per tick it takes, paced by its 16-bit half-period count and compare) and
// a result queue, so either side may stall independently. Writes to
// device_address and half_period_ticks take effect at once, a shorter half
// period ending the current half at once; issue them only while no transfer
// is in flight.
`default_nettype none

module i2c_master_write_engine
    import i2cw_pkg::*;
#(
    parameter int CMD_QUEUE_DEPTH = CMD_QUEUE_DEPTH_DEFAULT,
    parameter int RES_QUEUE_DEPTH = RES_QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  i_request,
    input  wire logic [1:0]            i_kind,
    input  wire logic [7:0]            i_payload,
    input  wire logic                  i_sda_in,
    output logic                       empty,
    input  wire logic                  pop,
    output logic                       o_scl,
    output logic                       o_sda_out,
    output logic                       o_sda_drive,
    output logic                       o_busy_res,
    output logic                       o_done_res,
    output logic                       o_nack_seen,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    q_push, q_full, q_empty, q_pop;
    t_item   q_in_item, q_out_item;
    logic    res_push, res_full;
    t_result res_in, res_out;

    i2cw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_request (i_request),
        .i_kind    (i_kind),
        .i_payload (i_payload),
        .i_sda_in  (i_sda_in),
        .o_q_push  (q_push),
        .o_q_item  (q_in_item),
        .i_q_full  (q_full)
    );

    i2cw_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out_item),
        .o_empty (q_empty)
    );

    i2cw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (!q_empty),
        .i_item       (q_out_item),
        .o_item_pop   (q_pop),
        .o_res_push   (res_push),
        .o_res        (res_in),
        .i_res_full   (res_full)
    );

    i2cw_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_scl       = res_out.scl;
    assign o_sda_out   = res_out.sda_out;
    assign o_sda_drive = res_out.sda_drive;
    assign o_busy_res  = res_out.busy_res;
    assign o_done_res  = res_out.done_res;
    assign o_nack_seen = res_out.nack_seen;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import i2cw_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_HI,
        PH_START_LO,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_STOP_LOW,
        PH_STOP_CLK,
        PH_STOP_REL
    } bus_phase_e;

    typedef struct packed {
        logic       request;
        logic [1:0] kind;
        logic [7:0] payload;
        logic       sda_in;
    } tick_t;

    // tracks the bus engine tick by tick and holds the line levels still owed
    class bus_line_tracker;
        logic [6:0]  dev_addr;
        logic [15:0] half_ticks;
        bus_phase_e  phase;
        logic [15:0] tick_cnt;
        logic [3:0]  bit_idx;
        logic [1:0]  byte_idx;
        logic [7:0]  shifter;
        logic [1:0]  kind_q;
        logic [7:0]  payload_q;
        logic        nack_q;
        int          checked;
        t_result     expected_levels[$];

        function new();
            dev_addr   = DEVICE_ADDRESS_RESET;
            half_ticks = HALF_PERIOD_RESET;
            phase      = PH_IDLE;
            tick_cnt   = '0;
            bit_idx    = '0;
            byte_idx   = '0;
            shifter    = '0;
            kind_q     = '0;
            payload_q  = '0;
            nack_q     = 1'b0;
            checked    = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
            if (idx == REG_DEVICE_ADDRESS) begin
                dev_addr = val[6:0];
            end else begin
                half_ticks = val;
            end
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        function bit is_idle();
            return phase == PH_IDLE;
        endfunction

        // next tick is the one on which the acknowledge is sampled
        function bit at_ack_sample();
            return phase == PH_ACK_HIGH && tick_cnt == 16'd0;
        endfunction

        function int frame_len();
            return (kind_q == KIND_PROBE) ? 1 : 3;
        endfunction

        function logic [7:0] frame_byte(input logic [1:0] idx);
            if (kind_q == KIND_PROBE) return {payload_q[6:0], 1'b0};
            if (idx == 2'd0) return {dev_addr, 1'b0};
            if (idx == 2'd1) return (kind_q == KIND_DATA) ? CTRL_DATA : CTRL_COMMAND;
            return payload_q;
        endfunction

        function void note_tick(input tick_t t);
            t_result r;
            int      hp;
            logic    bitv;
            hp   = (half_ticks == 16'd0) ? 1 : int'(half_ticks);
            bitv = shifter[7];
            r = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1, busy_res: 1'b1, default: 1'b0};

            if (phase == PH_IDLE && t.request && t.kind != KIND_RESERVED) begin
                kind_q    = t.kind;
                payload_q = t.payload;
                nack_q    = 1'b0;
                tick_cnt  = '0;
                bit_idx   = '0;
                byte_idx  = '0;
                phase     = PH_START_HI;
            end

            case (phase)
                PH_START_HI: ;
                PH_START_LO: r.sda_out = 1'b0;
                PH_BIT_LOW: begin
                    r.scl     = 1'b0;
                    r.sda_out = bitv;
                end
                PH_BIT_HIGH: r.sda_out = bitv;
                PH_ACK_LOW: begin
                    r.scl       = 1'b0;
                    r.sda_drive = 1'b0;
                end
                PH_ACK_HIGH: begin
                    r.sda_drive = 1'b0;
                    if (tick_cnt == 16'd0 && t.sda_in) nack_q = 1'b1;
                end
                PH_STOP_LOW: begin
                    r.scl     = 1'b0;
                    r.sda_out = 1'b0;
                end
                PH_STOP_CLK: r.sda_out = 1'b0;
                PH_STOP_REL: ;
                default: begin
                    phase      = PH_IDLE;
                    r.busy_res = 1'b0;
                end
            endcase

            if (phase != PH_IDLE) begin
                if (int'(tick_cnt) + 1 < hp) begin
                    tick_cnt = tick_cnt + 16'd1;
                end else begin
                    tick_cnt = '0;
                    case (phase)
                        PH_START_HI: phase = PH_START_LO;
                        PH_START_LO: begin
                            shifter = frame_byte(2'd0);
                            bit_idx = '0;
                            phase   = PH_BIT_LOW;
                        end
                        PH_BIT_LOW: phase = PH_BIT_HIGH;
                        PH_BIT_HIGH: begin
                            shifter = {shifter[6:0], 1'b0};
                            bit_idx = bit_idx + 4'd1;
                            phase   = (bit_idx >= 4'd8) ? PH_ACK_LOW : PH_BIT_LOW;
                        end
                        PH_ACK_LOW: phase = PH_ACK_HIGH;
                        PH_ACK_HIGH: begin
                            byte_idx = byte_idx + 2'd1;
                            if (int'(byte_idx) < frame_len()) begin
                                shifter = frame_byte(byte_idx);
                                bit_idx = '0;
                                phase   = PH_BIT_LOW;
                            end else begin
                                phase = PH_STOP_LOW;
                            end
                        end
                        PH_STOP_LOW: phase = PH_STOP_CLK;
                        PH_STOP_CLK: phase = PH_STOP_REL;
                        default: begin
                            r.done_res  = 1'b1;
                            r.nack_seen = nack_q;
                            phase       = PH_IDLE;
                        end
                    endcase
                end
            end
            expected_levels.push_back(r);
        endfunction

        function bit check_levels(input t_result got, output string msg);
            t_result want;
            msg = "";
            if (expected_levels.size() == 0) begin
                msg = $sformatf("result %b arrived with nothing expected", got);
                return 1'b0;
            end
            want = expected_levels.pop_front();
            checked++;
            if (got.scl !== want.scl)
                msg = {msg, $sformatf(" scl %b/%b", got.scl, want.scl)};
            if (got.sda_out !== want.sda_out)
                msg = {msg, $sformatf(" sda_out %b/%b", got.sda_out, want.sda_out)};
            if (got.sda_drive !== want.sda_drive)
                msg = {msg, $sformatf(" sda_drive %b/%b", got.sda_drive, want.sda_drive)};
            if (got.busy_res !== want.busy_res)
                msg = {msg, $sformatf(" busy %b/%b", got.busy_res, want.busy_res)};
            if (got.done_res !== want.done_res)
                msg = {msg, $sformatf(" done %b/%b", got.done_res, want.done_res)};
            if (got.nack_seen !== want.nack_seen)
                msg = {msg, $sformatf(" nack %b/%b", got.nack_seen, want.nack_seen)};
            if (msg == "") return 1'b1;
            msg = $sformatf("tick %0d (got/expected):%s", checked, msg);
            return 1'b0;
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic                  tick_request;
    logic [1:0]            tick_kind;
    logic [7:0]            tick_payload;
    logic                  tick_sda_in;
    logic                  empty;
    logic                  pop;
    logic                  o_scl;
    logic                  o_sda_out;
    logic                  o_sda_drive;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic                  o_nack_seen;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bus_line_tracker line_sb;
    int mismatches    = 0;
    int burst_left    = 0;
    bit no_gaps       = 1'b0;
    int long_hold_req = 0;

    always #10 i_clk = ~i_clk;

    i2c_master_write_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_request   (tick_request),
        .i_kind      (tick_kind),
        .i_payload   (tick_payload),
        .i_sda_in    (tick_sda_in),
        .empty       (empty),
        .pop         (pop),
        .o_scl       (o_scl),
        .o_sda_out   (o_sda_out),
        .o_sda_drive (o_sda_drive),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_nack_seen (o_nack_seen),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    task automatic flag_mismatch(input string msg);
        if (mismatches < 200) $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // offers one tick, with a random gap whenever a burst runs out
    task automatic send_tick(input tick_t t);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        push         <= 1'b1;
        tick_request <= t.request;
        tick_kind    <= t.kind;
        tick_payload <= t.payload;
        tick_sda_in  <= t.sda_in;
        do @(posedge i_clk); while (full);
        line_sb.note_tick(t);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        push <= 1'b0;
        burst_left = 0;
        while (line_sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        line_sb.set_reg(idx, val);
    endtask

    // ticks on an idle bus, the first one a request of the reserved kind
    task automatic send_idle(input int n);
        tick_t t;
        for (int j = 0; j < n; j++) begin
            t.request = (j == 0);
            t.kind    = KIND_RESERVED;
            t.payload = 8'($urandom);
            t.sda_in  = j[0];
            send_tick(t);
        end
    endtask

    // one frame start to stop; requests keep coming while busy and must be ignored
    task automatic run_frame(input logic [1:0] k, input logic [7:0] p,
                             input logic [2:0] nack_mask);
        tick_t t;
        int    acks;
        acks      = 0;
        t.request = 1'b1;
        t.kind    = k;
        t.payload = p;
        t.sda_in  = 1'b0;
        send_tick(t);
        while (!line_sb.is_idle()) begin
            t.request = 1'b1;
            t.kind    = 2'($urandom_range(0, 3));
            t.payload = 8'($urandom);
            t.sda_in  = 1'($urandom_range(0, 1));
            if (line_sb.at_ack_sample()) begin
                t.sda_in = nack_mask[acks];
                acks++;
            end
            send_tick(t);
        end
    endtask

    // mostly well-formed frames with random content, ending on an idle bus
    task automatic run_random(input int budget, input bit steady);
        tick_t t;
        int    count;
        count   = 0;
        no_gaps = steady;
        while (count < budget || !line_sb.is_idle()) begin
            t.payload = 8'($urandom);
            t.sda_in  = 1'($urandom_range(0, 1));
            if (line_sb.is_idle()) begin
                t.request = ($urandom_range(0, 9) != 0);
                t.kind    = ($urandom_range(0, 15) == 0) ? KIND_RESERVED
                                                         : 2'($urandom_range(0, 2));
            end else begin
                t.request = 1'($urandom_range(0, 1));
                t.kind    = 2'($urandom_range(0, 3));
            end
            if (line_sb.at_ack_sample()) t.sda_in = ($urandom_range(0, 7) == 0);
            send_tick(t);
            count++;
        end
        no_gaps = 1'b0;
    endtask

    initial begin : result_sink
        t_result got;
        string   msg;
        int      hold_left;
        int      pattern_left;
        int      stall_mode;
        hold_left    = 0;
        pattern_left = 0;
        stall_mode   = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                got = {o_scl, o_sda_out, o_sda_drive, o_busy_res, o_done_res, o_nack_seen};
                if (!line_sb.check_levels(got, msg)) flag_mismatch(msg);
            end
            if (hold_left == 0 && long_hold_req != 0) begin
                hold_left     = long_hold_req;
                long_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    stall_mode   = $urandom_range(0, 3);
                    pattern_left = $urandom_range(10, 60);
                end
                pattern_left--;
                case (stall_mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= (pattern_left % 5 != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        push         <= 1'b0;
        tick_request <= 1'b0;
        tick_kind    <= KIND_COMMAND;
        tick_payload <= '0;
        tick_sda_in  <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= REG_DEVICE_ADDRESS;
        cfg_data     <= '0;
        rst_n        <= 1'b0;
        line_sb = new();
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // reset half period first, then reset address, then the corners
        send_idle(3);
        run_frame(KIND_PROBE, 8'hFF, 3'b001);
        write_reg(REG_HALF_PERIOD, 16'd1);
        run_frame(KIND_COMMAND, 8'hFF, 3'b000);
        run_frame(KIND_RESERVED, 8'h12, 3'b000);
        run_frame(KIND_DATA, 8'h00, 3'b010);
        run_frame(KIND_PROBE, 8'h00, 3'b000);
        write_reg(REG_DEVICE_ADDRESS, 16'd127);
        run_frame(KIND_COMMAND, 8'h5A, 3'b100);
        write_reg(REG_DEVICE_ADDRESS, 16'd0);
        run_frame(KIND_DATA, 8'hA5, 3'b111);
        // zero half period runs like one
        write_reg(REG_HALF_PERIOD, 16'd0);
        run_frame(KIND_PROBE, 8'hD5, 3'b000);
        write_reg(REG_HALF_PERIOD, 16'hFFFF);
        send_idle(4);

        for (int i = 0; i < 4; i++) begin
            write_reg(REG_HALF_PERIOD, 16'($urandom_range(0, 2)));
            write_reg(REG_DEVICE_ADDRESS, 16'($urandom_range(0, 127)));
            // long receiver hold-off so the block fills and stalls its input
            if (i == 1) long_hold_req = 150;
            run_random(16, (i % 3) == 0);
        end

        push <= 1'b0;
        while (line_sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
